FILE: hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operand and result widths, the operation codes and derived datapath sizes.
// ----------------------------------------------------------------------------
package rau_pkg;

  // operand fields: low OPERAND_WIDTH bits, two's complement
  localparam int OPERAND_WIDTH = 16;
  // result fields
  localparam int OUT_WIDTH     = 34;
  // raw cross-multiplied values, signed, one guard bit for the sum
  localparam int RAW_WIDTH     = 2 * OPERAND_WIDTH + 1;
  // magnitudes of raw values, gcd operands and quotients
  localparam int MAG_WIDTH     = 2 * OPERAND_WIDTH;
  // bit counter of the restoring divider
  localparam int CNT_WIDTH     = $clog2(MAG_WIDTH);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rau_op_t;

  typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
  typedef logic signed [OUT_WIDTH-1:0]     result_t;

endpackage

FILE: hw/rtl/rau_ifs.sv
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if: valid/ready channels of the rational arithmetic unit
// One word on the input side is an operation and two fractions; one word on
// the result side is a reduced fraction and the zero-denominator flag.
// ----------------------------------------------------------------------------
interface rau_in_if import rau_pkg::*; ();
  logic     valid;
  logic     ready;
  rau_op_t  operation;
  operand_t left_num;
  operand_t left_den;
  operand_t right_num;
  operand_t right_den;

  modport source (
    output valid, operation, left_num, left_den, right_num, right_den,
    input  ready
  );
  modport sink (
    input  valid, operation, left_num, left_den, right_num, right_den,
    output ready
  );
endinterface

interface rau_out_if import rau_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t result_num;
  result_t result_den;
  logic    zero_den_fixed;

  modport source (
    output valid, result_num, result_den, zero_den_fixed,
    input  ready
  );
  modport sink (
    input  valid, result_num, result_den, zero_den_fixed,
    output ready
  );
endinterface

FILE: hw/rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add/subtract/multiply/divide with reduction
// Cross-multiplies two fractions, fixes a zero denominator to 1, then reduces
// numerator and denominator by the gcd of their magnitudes.
// ----------------------------------------------------------------------------
// One word is worked on at a time; in_ch.ready is high only while the unit is
// idle. From acceptance to the result register a word goes through three
// products on the single 16x16 multiplier, a setup step, binary gcd (one
// shift, swap or subtract on the shared 33-bit subtractor per cycle), and two
// restoring divisions of 32 quotient bits on the same subtractor. A zero
// numerator skips the gcd and divisions. The result waits in an output
// register until taken; each sign of the result follows its raw value, but a
// zero numerator gets a denominator of +1, and the denominator is not
// normalized to be positive.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  rau_in_if.sink       in_ch,
  rau_out_if.source    out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_GCD,
    S_DIV,
    S_DONE
  } state_t;

  localparam logic [1:0] STEP_CROSS  = 2'd0;
  localparam logic [1:0] STEP_SECOND = 2'd1;
  localparam logic [1:0] STEP_DEN    = 2'd2;

  // control
  state_t                 state_r, state_nxt;
  logic [1:0]             step_r, step_nxt;
  logic [CNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic                   div_sel_r, div_sel_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // operands
  rau_op_t                op_r, op_nxt;
  operand_t               ln_r, ln_nxt, ld_r, ld_nxt, rn_r, rn_nxt, rd_r, rd_nxt;

  // raw values and flags
  logic signed [RAW_WIDTH-1:0] num_raw_r, num_raw_nxt, den_raw_r, den_raw_nxt;
  logic                   num_neg_r, num_neg_nxt, den_neg_r, den_neg_nxt;
  logic                   fixed_r, fixed_nxt;

  // magnitudes (later quotients), gcd pair, division remainder
  logic [MAG_WIDTH-1:0]   mn_r, mn_nxt, md_r, md_nxt;
  logic [MAG_WIDTH-1:0]   ga_r, ga_nxt, gb_r, gb_nxt;
  logic [MAG_WIDTH-1:0]   rem_r, rem_nxt;

  // result register
  result_t                res_num_r, res_num_nxt, res_den_r, res_den_nxt;
  logic                   res_fixed_r, res_fixed_nxt;

  // shared multiplier
  operand_t                        mul_x, mul_y;
  logic signed [MAG_WIDTH-1:0]     prod;
  logic signed [RAW_WIDTH-1:0]     prod_ext;

  // shared subtractor
  logic [MAG_WIDTH:0]     sub_a, sub_b;
  logic [MAG_WIDTH+1:0]   sub_res;
  logic                   sub_borrow;
  logic                   sub_zero;

  // setup helpers
  logic signed [RAW_WIDTH-1:0] num_neg_val, den_neg_val;
  logic [MAG_WIDTH-1:0]   num_mag, den_mag;
  logic                   dvd_msb;
  logic                   q_bit;

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_num     = res_num_r;
  assign out_ch.result_den     = res_den_r;
  assign out_ch.zero_den_fixed = res_fixed_r;

  // select multiplier operands per step
  always_comb begin
    unique case (step_r)
      STEP_CROSS: begin
        mul_x = ln_r;
        mul_y = (op_r == OP_MUL) ? rn_r : rd_r;
      end
      STEP_SECOND: begin
        mul_x = ld_r;
        mul_y = rn_r;
      end
      STEP_DEN: begin
        mul_x = ld_r;
        mul_y = (op_r == OP_DIV) ? rn_r : rd_r;
      end
      default: begin
        mul_x = ln_r;
        mul_y = rd_r;
      end
    endcase
  end

  assign prod     = mul_x * mul_y;
  assign prod_ext = {{(RAW_WIDTH - MAG_WIDTH){prod[MAG_WIDTH-1]}}, prod};

  // magnitudes of the raw values
  assign num_neg_val = '0 - num_raw_r;
  assign den_neg_val = '0 - den_raw_r;
  assign num_mag = num_raw_r[RAW_WIDTH-1] ? num_neg_val[MAG_WIDTH-1:0]
                                          : num_raw_r[MAG_WIDTH-1:0];
  assign den_mag = den_raw_r[RAW_WIDTH-1] ? den_neg_val[MAG_WIDTH-1:0]
                                          : den_raw_r[MAG_WIDTH-1:0];

  // feed the subtractor: gcd compare or divider trial
  assign dvd_msb = div_sel_r ? md_r[MAG_WIDTH-1] : mn_r[MAG_WIDTH-1];
  always_comb begin
    if (state_r == S_DIV) begin
      sub_a = {rem_r, dvd_msb};
      sub_b = {1'b0, ga_r};
    end else begin
      sub_a = {1'b0, ga_r};
      sub_b = {1'b0, gb_r};
    end
  end

  assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_res[MAG_WIDTH+1];
  assign sub_zero   = (sub_res == '0);
  assign q_bit      = ~sub_borrow;

  // sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    div_sel_nxt   = div_sel_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    ln_nxt        = ln_r;
    ld_nxt        = ld_r;
    rn_nxt        = rn_r;
    rd_nxt        = rd_r;
    num_raw_nxt   = num_raw_r;
    den_raw_nxt   = den_raw_r;
    num_neg_nxt   = num_neg_r;
    den_neg_nxt   = den_neg_r;
    fixed_nxt     = fixed_r;
    mn_nxt        = mn_r;
    md_nxt        = md_r;
    ga_nxt        = ga_r;
    gb_nxt        = gb_r;
    rem_nxt       = rem_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    res_fixed_nxt = res_fixed_r;

    // drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.operation;
          ln_nxt    = in_ch.left_num;
          ld_nxt    = in_ch.left_den;
          rn_nxt    = in_ch.right_num;
          rd_nxt    = in_ch.right_den;
          step_nxt  = STEP_CROSS;
          state_nxt = S_MUL;
        end
      end

      // cross multiply, one product per cycle
      S_MUL: begin
        unique case (step_r)
          STEP_CROSS: begin
            num_raw_nxt = prod_ext;
            step_nxt    = STEP_SECOND;
          end
          STEP_SECOND: begin
            if (op_r == OP_ADD) begin
              num_raw_nxt = num_raw_r + prod_ext;
            end else if (op_r == OP_SUB) begin
              num_raw_nxt = num_raw_r - prod_ext;
            end
            step_nxt = STEP_DEN;
          end
          STEP_DEN: begin
            den_raw_nxt = prod_ext;
            state_nxt   = S_PREP;
          end
          default: begin
            step_nxt = STEP_CROSS;
          end
        endcase
      end

      // fix a zero denominator, load magnitudes
      S_PREP: begin
        fixed_nxt   = (den_raw_r == '0);
        num_neg_nxt = num_raw_r[RAW_WIDTH-1];
        den_neg_nxt = den_raw_r[RAW_WIDTH-1];
        if (num_raw_r == '0) begin
          mn_nxt      = '0;
          md_nxt      = MAG_WIDTH'(1);
          den_neg_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else begin
          mn_nxt    = num_mag;
          md_nxt    = (den_raw_r == '0) ? MAG_WIDTH'(1) : den_mag;
          ga_nxt    = num_mag;
          gb_nxt    = (den_raw_r == '0) ? MAG_WIDTH'(1) : den_mag;
          state_nxt = S_GCD;
        end
      end

      // binary gcd; common factors of two come out of the dividends directly
      S_GCD: begin
        priority if (!ga_r[0] && !gb_r[0]) begin
          ga_nxt = ga_r >> 1;
          gb_nxt = gb_r >> 1;
          mn_nxt = mn_r >> 1;
          md_nxt = md_r >> 1;
        end else if (sub_zero) begin
          rem_nxt     = '0;
          cnt_nxt     = '0;
          div_sel_nxt = 1'b0;
          state_nxt   = S_DIV;
        end else if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_nxt = gb_r >> 1;
        end else if (sub_borrow) begin
          ga_nxt = gb_r;
          gb_nxt = ga_r;
        end else begin
          ga_nxt = sub_res[MAG_WIDTH-1:0];
        end
      end

      // restoring division by the odd gcd part, numerator then denominator
      S_DIV: begin
        rem_nxt = sub_borrow ? sub_a[MAG_WIDTH-1:0] : sub_res[MAG_WIDTH-1:0];
        if (div_sel_r) begin
          md_nxt = {md_r[MAG_WIDTH-2:0], q_bit};
        end else begin
          mn_nxt = {mn_r[MAG_WIDTH-2:0], q_bit};
        end
        if (cnt_r == CNT_WIDTH'(MAG_WIDTH - 1)) begin
          cnt_nxt = '0;
          if (div_sel_r) begin
            state_nxt = S_DONE;
          end else begin
            div_sel_nxt = 1'b1;
            rem_nxt     = '0;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_WIDTH'(1);
        end
      end

      // load the result register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          res_num_nxt   = num_neg_r ? ('0 - result_t'({2'b00, mn_r}))
                                    : result_t'({2'b00, mn_r});
          res_den_nxt   = den_neg_r ? ('0 - result_t'({2'b00, md_r}))
                                    : result_t'({2'b00, md_r});
          res_fixed_nxt = fixed_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state, registered outputs and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_CROSS;
      cnt_r       <= '0;
      div_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      div_sel_r   <= div_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    ln_r        <= ln_nxt;
    ld_r        <= ld_nxt;
    rn_r        <= rn_nxt;
    rd_r        <= rd_nxt;
    num_raw_r   <= num_raw_nxt;
    den_raw_r   <= den_raw_nxt;
    num_neg_r   <= num_neg_nxt;
    den_neg_r   <= den_neg_nxt;
    fixed_r     <= fixed_nxt;
    mn_r        <= mn_nxt;
    md_r        <= md_nxt;
    ga_r        <= ga_nxt;
    gb_r        <= gb_nxt;
    rem_r       <= rem_nxt;
    res_num_r   <= res_num_nxt;
    res_den_r   <= res_den_nxt;
    res_fixed_r <= res_fixed_nxt;
  end

endmodule

FILE: hw/rtl/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker: port-level checks of the rational arithmetic unit
// Watches the channel ports over time; attached to rational_arithmetic_unit by bind.
// ----------------------------------------------------------------------------
module rau_checker import rau_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t result_num,
  input result_t result_den,
  input logic    zero_den_fixed
);

  // busy right after taking a word
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("input still ready after a word was accepted");

  // a stalled result holds
  a_result_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(result_num) && $stable(result_den)
       && $stable(zero_den_fixed))
  ) else $error("result changed or dropped while stalled");

  // zero numerator forces a unit denominator
  a_zero_num_unit_den: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && (result_num == '0)) |-> (result_den == result_t'(1))
  ) else $error("zero numerator without unit denominator");

  // a fixed zero denominator reduces to exactly one
  a_fixed_den_one: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && zero_den_fixed) |-> (result_den == result_t'(1))
  ) else $error("fixed denominator is not one");

  // otherwise the denominator is never zero
  a_den_nonzero: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (result_den != '0)
  ) else $error("zero denominator in result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .result_num     (out_ch.result_num),
  .result_den     (out_ch.result_den),
  .zero_den_fixed (out_ch.zero_den_fixed)
);
